### src/nmea_sentence_field_extractor_defines.svh
// Assertion macros used by the extractor back end.
`ifndef NMEA_SENTENCE_FIELD_EXTRACTOR_DEFINES_SVH
`define NMEA_SENTENCE_FIELD_EXTRACTOR_DEFINES_SVH

`ifndef SYNTHESIS

`define NSFE_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("nsfe: same-cycle check failed");

`define NSFE_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("nsfe: next-cycle check failed");

`else

`define NSFE_ASSERT_IMPLY(label, clk, rst, ante, cons)

`define NSFE_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

### src/nsfe_pkg.sv
`default_nettype none

package nsfe_pkg;

  localparam int VALUE_WIDTH_DEFAULT = 32;
  localparam int MANT_WIDTH = 32;
  localparam int CFG_DATA_WIDTH = 5;
  localparam int CFG_INDEX_WIDTH = 1;
  localparam int QUEUE_DEPTH = 2;
  localparam int SENTENCE_COUNT = 6;
  localparam int FIELD_SLOTS = 17;

  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_SENTENCE_SELECT = 1'b0;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_FIELD_NUMBER = 1'b1;

  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;
  localparam logic [7:0] CHAR_COMMA = 8'h2C;
  localparam logic [7:0] CHAR_DOLLAR = 8'h24;
  localparam logic [7:0] CHAR_STAR = 8'h2A;
  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_LF = 8'h0A;
  localparam logic [7:0] CHAR_DOT = 8'h2E;

  localparam logic [2:0] HDR_SUM_START = 3'd3;
  localparam logic [2:0] HDR_LAST = 3'd5;
  localparam logic [3:0] FRAC_MAX = 4'd9;

  typedef enum logic [2:0] {
    PH_SEARCH,
    PH_HEADER,
    PH_COUNT,
    PH_FIELD,
    PH_DONE
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_NO_SENTENCE = 2'd1,
    ST_NO_FIELD    = 2'd2,
    ST_MALFORMED   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    KIND_FLOAT = 2'd0,
    KIND_INT   = 2'd1,
    KIND_CHAR  = 2'd2
  } kind_t;

  typedef struct packed {
    logic [7:0] data;
    logic       first;
    logic       last;
    logic       is_digit;
    logic       is_comma;
    logic       is_dollar;
    logic       is_end;
    logic       is_dot;
  } entry_t;

  typedef struct packed {
    logic [2:0] sel;
    logic [4:0] fn;
  } cfg_t;

  localparam kind_t TYPE_TAB [SENTENCE_COUNT][FIELD_SLOTS] = '{
    '{KIND_FLOAT, KIND_CHAR, KIND_FLOAT, KIND_CHAR, KIND_FLOAT, KIND_CHAR,
      KIND_FLOAT, KIND_FLOAT, KIND_INT, KIND_INT, KIND_CHAR, KIND_CHAR,
      KIND_FLOAT, KIND_FLOAT, KIND_FLOAT, KIND_FLOAT, KIND_FLOAT},
    '{KIND_INT, KIND_CHAR, KIND_INT, KIND_CHAR, KIND_INT, KIND_CHAR,
      KIND_INT, KIND_CHAR, KIND_CHAR, KIND_FLOAT, KIND_FLOAT, KIND_FLOAT,
      KIND_FLOAT, KIND_FLOAT, KIND_FLOAT, KIND_FLOAT, KIND_FLOAT},
    '{KIND_FLOAT, KIND_FLOAT, KIND_CHAR, KIND_FLOAT, KIND_CHAR, KIND_INT,
      KIND_INT, KIND_INT, KIND_INT, KIND_CHAR, KIND_INT, KIND_CHAR,
      KIND_INT, KIND_INT, KIND_FLOAT, KIND_FLOAT, KIND_FLOAT},
    '{KIND_CHAR, KIND_INT, KIND_INT, KIND_INT, KIND_INT, KIND_INT,
      KIND_INT, KIND_INT, KIND_INT, KIND_INT, KIND_INT, KIND_INT,
      KIND_INT, KIND_INT, KIND_INT, KIND_INT, KIND_INT},
    '{KIND_INT, KIND_INT, KIND_INT, KIND_INT, KIND_INT, KIND_INT,
      KIND_INT, KIND_FLOAT, KIND_FLOAT, KIND_FLOAT, KIND_FLOAT, KIND_FLOAT,
      KIND_FLOAT, KIND_FLOAT, KIND_FLOAT, KIND_FLOAT, KIND_FLOAT},
    '{KIND_FLOAT, KIND_CHAR, KIND_FLOAT, KIND_CHAR, KIND_FLOAT, KIND_CHAR,
      KIND_CHAR, KIND_FLOAT, KIND_FLOAT, KIND_FLOAT, KIND_FLOAT, KIND_FLOAT,
      KIND_FLOAT, KIND_FLOAT, KIND_FLOAT, KIND_FLOAT, KIND_FLOAT}
  };

  function automatic logic [9:0] name_sum(input logic [2:0] sel);
    logic [9:0] s;
    case (sel)
      3'd0:    s = 10'd226;
      3'd1:    s = 10'd241;
      3'd2:    s = 10'd207;
      3'd3:    s = 10'd219;
      3'd4:    s = 10'd240;
      3'd5:    s = 10'd223;
      default: s = 10'd0;
    endcase
    return s;
  endfunction

  function automatic logic [4:0] type_len(input logic [2:0] sel);
    logic [4:0] n;
    case (sel)
      3'd0:    n = 5'd12;
      3'd1:    n = 5'd9;
      3'd2:    n = 5'd14;
      3'd3:    n = 5'd17;
      3'd4:    n = 5'd7;
      3'd5:    n = 5'd7;
      default: n = 5'd0;
    endcase
    return n;
  endfunction

  // The slot wraps modulo the table width, and field zero maps to slot zero.
  function automatic kind_t field_kind(input logic [2:0] sel, input logic [4:0] fn);
    logic [4:0] idx;
    kind_t      k;
    if (fn == 5'd0) begin
      idx = 5'd0;
    end else if (fn <= 5'(FIELD_SLOTS)) begin
      idx = fn - 5'd1;
    end else begin
      idx = fn - 5'(FIELD_SLOTS + 1);
    end
    if (sel < 3'(SENTENCE_COUNT)) begin
      k = TYPE_TAB[sel][idx];
    end else begin
      k = KIND_FLOAT;
    end
    return k;
  endfunction

endpackage

`default_nettype wire

### src/nsfe_front.sv
`default_nettype none

module nsfe_front
  import nsfe_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] data_byte,
  input  logic       first_byte,
  input  logic       last_byte,
  output logic       q_valid,
  input  logic       q_ready,
  output entry_t     q_entry
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  entry_t             slots [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  entry_t             in_entry;
  logic               push;
  logic               pop;

  always_comb begin
    in_entry.data      = data_byte;
    in_entry.first     = first_byte;
    in_entry.last      = last_byte;
    in_entry.is_digit  = data_byte inside {[CHAR_ZERO:CHAR_NINE]};
    in_entry.is_comma  = data_byte == CHAR_COMMA;
    in_entry.is_dollar = data_byte == CHAR_DOLLAR;
    in_entry.is_end    = data_byte inside {CHAR_STAR, CHAR_CR, CHAR_LF, CHAR_DOLLAR};
    in_entry.is_dot    = data_byte == CHAR_DOT;
  end

  assign in_ready = count != CNT_W'(QUEUE_DEPTH);
  assign q_valid  = count != '0;
  assign q_entry  = slots[rd_ptr];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

### src/nsfe_back.sv
`default_nettype none

`include "nmea_sentence_field_extractor_defines.svh"

module nsfe_back
  import nsfe_pkg::*;
#(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  cfg_t                  cfg,
  input  logic                  q_valid,
  output logic                  q_ready,
  input  entry_t                q_entry,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [1:0]            status,
  output logic [1:0]            value_kind,
  output logic [MANT_WIDTH-1:0] mantissa,
  output logic [3:0]            fraction_digits,
  output logic [7:0]            char_value
);

  localparam int ACC_W = (VALUE_WIDTH > MANT_WIDTH) ? MANT_WIDTH : VALUE_WIDTH;

  phase_t             phase, phase_next, cur_phase, post_phase;
  logic [2:0]         header_position, header_position_next, cur_hp, hp_inc;
  logic [9:0]         header_sum, header_sum_next, cur_sum, sum_add;
  logic [7:0]         comma_count, comma_count_next, cur_cc, cc_inc;
  logic [ACC_W-1:0]   digit_accumulator, digit_accumulator_next, cur_acc;
  logic [3:0]         fraction_count, fraction_count_next, cur_frac;
  logic               point_seen, point_seen_next, cur_pt;
  logic [7:0]         captured_char, captured_char_next, cur_cap;
  logic               error_flag, error_flag_next, cur_err;
  logic               field_started, field_started_next, cur_started;

  logic [7:0]         b;
  logic               pop, emit, hdr_done, hdr_match, fn_bad, reach, close;
  logic               sw_emit2, sw_finish;
  kind_t              kind;
  logic [ACC_W+3:0]   prod;
  logic               ovf;

  status_t            res_status;
  kind_t              res_kind;
  logic [ACC_W-1:0]   res_mant;
  logic [3:0]         res_frac;
  logic [7:0]         res_char;

  assign b       = q_entry.data;
  assign q_ready = !out_valid || out_ready;
  assign pop     = q_valid && q_ready;

  // A first byte clears the search state before the byte itself is parsed.
  assign cur_phase   = q_entry.first ? PH_SEARCH : phase;
  assign cur_hp      = q_entry.first ? '0 : header_position;
  assign cur_sum     = q_entry.first ? '0 : header_sum;
  assign cur_cc      = q_entry.first ? '0 : comma_count;
  assign cur_acc     = q_entry.first ? '0 : digit_accumulator;
  assign cur_frac    = q_entry.first ? '0 : fraction_count;
  assign cur_pt      = q_entry.first ? 1'b0 : point_seen;
  assign cur_cap     = q_entry.first ? '0 : captured_char;
  assign cur_err     = q_entry.first ? 1'b0 : error_flag;
  assign cur_started = q_entry.first ? 1'b0 : field_started;

  assign hp_inc    = cur_hp + 3'd1;
  assign sum_add   = (hp_inc >= HDR_SUM_START) ? cur_sum + {2'b00, b} : cur_sum;
  assign hdr_done  = hp_inc >= HDR_LAST;
  assign hdr_match = (cfg.sel < 3'(SENTENCE_COUNT)) && (sum_add == name_sum(cfg.sel));
  assign fn_bad    = (cfg.fn == 5'd0) || (cfg.fn > type_len(cfg.sel));
  assign cc_inc    = cur_cc + 8'd1;
  assign reach     = cc_inc == {3'b000, cfg.fn};
  assign close     = q_entry.is_comma || q_entry.is_end;
  assign kind      = field_kind(cfg.sel, cfg.fn);

  assign prod = {1'b0, cur_acc, 3'b000} + {3'b000, cur_acc, 1'b0}
              + {{ACC_W{1'b0}}, b[3:0]};
  assign ovf  = |prod[ACC_W+3:ACC_W];

  always_comb begin
    case (cur_phase)
      PH_SEARCH: post_phase = q_entry.is_dollar ? PH_HEADER : PH_SEARCH;
      PH_HEADER: begin
        if (q_entry.is_dollar || !hdr_done) begin
          post_phase = PH_HEADER;
        end else if (!hdr_match) begin
          post_phase = PH_SEARCH;
        end else begin
          post_phase = fn_bad ? PH_DONE : PH_COUNT;
        end
      end
      PH_COUNT: begin
        if (q_entry.is_comma) begin
          post_phase = reach ? PH_FIELD : PH_COUNT;
        end else begin
          post_phase = q_entry.is_end ? PH_DONE : PH_COUNT;
        end
      end
      PH_FIELD: post_phase = close ? PH_DONE : PH_FIELD;
      default:  post_phase = PH_DONE;
    endcase
  end

  assign sw_emit2 = (cur_phase == PH_HEADER && !q_entry.is_dollar && hdr_done
                     && hdr_match && fn_bad)
                 || (cur_phase == PH_COUNT && !q_entry.is_comma && q_entry.is_end);
  assign sw_finish = cur_phase == PH_FIELD && close;
  assign emit = (cur_phase != PH_DONE) && (sw_emit2 || sw_finish || q_entry.last);

  always_comb begin
    phase_next = emit ? PH_DONE : post_phase;
  end

  always_comb begin
    header_position_next   = cur_hp;
    header_sum_next        = cur_sum;
    comma_count_next       = cur_cc;
    digit_accumulator_next = cur_acc;
    fraction_count_next    = cur_frac;
    point_seen_next        = cur_pt;
    captured_char_next     = cur_cap;
    error_flag_next        = cur_err;
    field_started_next     = cur_started;
    case (cur_phase)
      PH_SEARCH: begin
        if (q_entry.is_dollar) begin
          header_position_next = '0;
          header_sum_next      = '0;
        end
      end
      PH_HEADER: begin
        if (q_entry.is_dollar) begin
          header_position_next = '0;
          header_sum_next      = '0;
        end else begin
          header_position_next = hp_inc;
          header_sum_next      = sum_add;
          if (hdr_done) begin
            comma_count_next = '0;
          end
        end
      end
      PH_COUNT: begin
        if (q_entry.is_comma) begin
          comma_count_next = cc_inc;
          if (reach) begin
            digit_accumulator_next = '0;
            fraction_count_next    = '0;
            point_seen_next        = 1'b0;
            captured_char_next     = '0;
            error_flag_next        = 1'b0;
            field_started_next     = 1'b0;
          end
        end
      end
      PH_FIELD: begin
        if (!close) begin
          field_started_next = 1'b1;
          if (!cur_started) begin
            captured_char_next = b;
          end
          if (kind != KIND_CHAR) begin
            if (q_entry.is_digit) begin
              if (kind == KIND_FLOAT && cur_pt && cur_frac >= FRAC_MAX) begin
                error_flag_next = 1'b1;
              end else begin
                if (kind == KIND_FLOAT && cur_pt) begin
                  fraction_count_next = cur_frac + 4'd1;
                end
                if (ovf) begin
                  digit_accumulator_next = '1;
                  error_flag_next        = 1'b1;
                end else begin
                  digit_accumulator_next = prod[ACC_W-1:0];
                end
              end
            end else if (q_entry.is_dot && kind == KIND_FLOAT && !cur_pt) begin
              point_seen_next = 1'b1;
            end else begin
              error_flag_next = 1'b1;
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    res_status = ST_NO_SENTENCE;
    res_kind   = KIND_FLOAT;
    res_mant   = '0;
    res_frac   = '0;
    res_char   = '0;
    if (sw_emit2) begin
      res_status = ST_NO_FIELD;
    end else if (sw_finish || post_phase == PH_FIELD) begin
      if (!field_started_next) begin
        res_status = ST_NO_FIELD;
      end else if (kind == KIND_CHAR) begin
        res_status = ST_OK;
        res_kind   = KIND_CHAR;
        res_char   = captured_char_next;
      end else begin
        res_status = error_flag_next ? ST_MALFORMED : ST_OK;
        res_kind   = kind;
        res_mant   = digit_accumulator_next;
        res_frac   = (kind == KIND_FLOAT) ? fraction_count_next : 4'd0;
      end
    end else if (post_phase == PH_COUNT) begin
      res_status = ST_NO_FIELD;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_SEARCH;
      header_position   <= '0;
      header_sum        <= '0;
      comma_count       <= '0;
      digit_accumulator <= '0;
      fraction_count    <= '0;
      point_seen        <= 1'b0;
      captured_char     <= '0;
      error_flag        <= 1'b0;
      field_started     <= 1'b0;
    end else if (pop) begin
      phase             <= phase_next;
      header_position   <= header_position_next;
      header_sum        <= header_sum_next;
      comma_count       <= comma_count_next;
      digit_accumulator <= digit_accumulator_next;
      fraction_count    <= fraction_count_next;
      point_seen        <= point_seen_next;
      captured_char     <= captured_char_next;
      error_flag        <= error_flag_next;
      field_started     <= field_started_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop && emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emit) begin
      status          <= res_status;
      value_kind      <= res_kind;
      mantissa        <= MANT_WIDTH'(res_mant);
      fraction_digits <= res_frac;
      char_value      <= res_char;
    end
  end

  `NSFE_ASSERT_NEXT(a_result_loaded, clk, rst, pop && emit, out_valid)
  `NSFE_ASSERT_IMPLY(a_quiet_after_result, clk, rst,
    pop && phase == PH_DONE && !q_entry.first, !emit)
  `NSFE_ASSERT_IMPLY(a_failure_is_bare, clk, rst,
    out_valid && (status == ST_NO_SENTENCE || status == ST_NO_FIELD),
    mantissa == '0 && value_kind == KIND_FLOAT && char_value == '0)
  `NSFE_ASSERT_IMPLY(a_fraction_bounded, clk, rst, 1'b1, fraction_count <= FRAC_MAX)

endmodule

`default_nettype wire

### src/nmea_sentence_field_extractor.sv
// NMEA 0183 sentence field extractor.
// Bytes of a text buffer arrive on the input channel (in_valid/in_ready with
// data_byte, first_byte and last_byte); first_byte opens a new buffer and
// last_byte closes it. At most one result, and with last_byte exactly one,
// leaves on the output channel (out_valid/out_ready) per buffer: status,
// value_kind, mantissa, fraction_digits and char_value of the selected field.
// The two registers, sentence_select and field_number, are written through
// cfg_write, cfg_index and cfg_data. The user writes them only while the
// block is idle; the block itself does not enforce this.
// One byte is taken every cycle while in_ready is high. An accepted byte is
// written into a two-entry queue; the back end parses it when it pops it,
// and that pop also loads the result register with the result it completes.
// The single-step multiply-by-ten accumulator in the back end sets that rate.
// While the receiver stalls, the result register holds, the back end stops,
// and in_ready falls once the queue is full.
// Reset empties the queue and the result register, returns the parser to the
// search for a dollar sign and sets the registers to RMC, field one.
`default_nettype none

module nmea_sentence_field_extractor
  import nsfe_pkg::*;
#(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write,
  input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [CFG_DATA_WIDTH-1:0]  cfg_data,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [7:0]                 data_byte,
  input  logic                       first_byte,
  input  logic                       last_byte,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [1:0]                 status,
  output logic [1:0]                 value_kind,
  output logic [MANT_WIDTH-1:0]      mantissa,
  output logic [3:0]                 fraction_digits,
  output logic [7:0]                 char_value
);

  cfg_t   cfg;
  logic   q_valid;
  logic   q_ready;
  entry_t q_entry;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sel <= 3'd0;
      cfg.fn  <= 5'd1;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_SENTENCE_SELECT: cfg.sel <= cfg_data[2:0];
        CFG_FIELD_NUMBER:    cfg.fn  <= cfg_data[4:0];
        default: begin
        end
      endcase
    end
  end

  nsfe_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .data_byte  (data_byte),
    .first_byte (first_byte),
    .last_byte  (last_byte),
    .q_valid    (q_valid),
    .q_ready    (q_ready),
    .q_entry    (q_entry)
  );

  nsfe_back #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .q_valid         (q_valid),
    .q_ready         (q_ready),
    .q_entry         (q_entry),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .status          (status),
    .value_kind      (value_kind),
    .mantissa        (mantissa),
    .fraction_digits (fraction_digits),
    .char_value      (char_value)
  );

endmodule

`default_nettype wire

### tb/sv/nmea_field_checker.sv
`default_nettype none

module nmea_field_checker
  import nsfe_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write,
  input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [CFG_DATA_WIDTH-1:0]  cfg_data,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  logic [7:0]                 data_byte,
  input  logic                       first_byte,
  input  logic                       last_byte,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  logic [1:0]                 status,
  input  logic [1:0]                 value_kind,
  input  logic [MANT_WIDTH-1:0]      mantissa,
  input  logic [3:0]                 fraction_digits,
  input  logic [7:0]                 char_value,
  output int                         failures,
  output int                         awaiting,
  output int                         results_due_total
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    status_t    st;
    kind_t      kind;
    logic [31:0] mant;
    logic [3:0]  frac;
    logic [7:0]  ch;
  } field_result_t;

  localparam kind_t KF = KIND_FLOAT;
  localparam kind_t KI = KIND_INT;
  localparam kind_t KC = KIND_CHAR;

  localparam logic [63:0] SAT_LIMIT = 64'hFFFF_FFFF;
  localparam logic [9:0] HEADER_SUMS [SENTENCE_COUNT] = '{
    10'd226, 10'd241, 10'd207, 10'd219, 10'd240, 10'd223
  };
  localparam logic [4:0] FIELD_COUNTS [SENTENCE_COUNT] = '{
    5'd12, 5'd9, 5'd14, 5'd17, 5'd7, 5'd7
  };
  localparam kind_t FIELD_TYPES [SENTENCE_COUNT][FIELD_SLOTS] = '{
    '{KF, KC, KF, KC, KF, KC, KF, KF, KI, KI, KC, KC, KF, KF, KF, KF, KF},
    '{KI, KC, KI, KC, KI, KC, KI, KC, KC, KF, KF, KF, KF, KF, KF, KF, KF},
    '{KF, KF, KC, KF, KC, KI, KI, KI, KI, KC, KI, KC, KI, KI, KF, KF, KF},
    '{KC, KI, KI, KI, KI, KI, KI, KI, KI, KI, KI, KI, KI, KI, KI, KI, KI},
    '{KI, KI, KI, KI, KI, KI, KI, KF, KF, KF, KF, KF, KF, KF, KF, KF, KF},
    '{KF, KC, KF, KC, KF, KC, KC, KF, KF, KF, KF, KF, KF, KF, KF, KF, KF}
  };

  logic [2:0]  sel = 3'd0;
  logic [4:0]  fnum = 5'd1;
  phase_t      ph = PH_SEARCH;
  logic [2:0]  hdr_pos = '0;
  logic [9:0]  hdr_sum = '0;
  logic [4:0]  commas = '0;
  logic [63:0] acc = '0;
  logic [3:0]  frac_cnt = '0;
  logic [7:0]  first_char = '0;
  bit          point_seen = 1'b0;
  bit          bad = 1'b0;
  bit          done = 1'b0;
  bit          started = 1'b0;

  field_result_t field_results_due [$];
  int fail_cnt = 0;
  int predicted = 0;

  function automatic void clear_search();
    ph = PH_SEARCH;
    hdr_pos = '0;
    hdr_sum = '0;
    commas = '0;
    acc = '0;
    frac_cnt = '0;
    point_seen = 1'b0;
    first_char = '0;
    bad = 1'b0;
    done = 1'b0;
    started = 1'b0;
  endfunction

  function automatic kind_t kind_of_field();
    int slot;
    slot = (fnum == 5'd0) ? 0 : (int'(fnum) - 1) % FIELD_SLOTS;
    if (sel >= 3'(SENTENCE_COUNT)) return KIND_FLOAT;
    return FIELD_TYPES[sel][slot];
  endfunction

  function automatic field_result_t give(input status_t st, input kind_t k,
                                         input logic [31:0] m, input logic [3:0] f,
                                         input logic [7:0] c);
    field_result_t r;
    r.st = st;
    r.kind = k;
    r.mant = m;
    r.frac = f;
    r.ch = c;
    done = 1'b1;
    ph = PH_DONE;
    return r;
  endfunction

  function automatic field_result_t finish_field();
    kind_t k;
    k = kind_of_field();
    if (!started) return give(ST_NO_FIELD, KIND_FLOAT, '0, '0, '0);
    if (k == KIND_CHAR) return give(ST_OK, KIND_CHAR, '0, '0, first_char);
    return give(bad ? ST_MALFORMED : ST_OK, k, acc[31:0],
                (k == KIND_FLOAT) ? frac_cnt : 4'd0, '0);
  endfunction

  function automatic void absorb(input logic [7:0] b);
    kind_t       k;
    logic [63:0] d;
    k = kind_of_field();
    if (!started) first_char = b;
    started = 1'b1;
    if (k == KIND_CHAR) return;
    if (b >= CHAR_ZERO && b <= CHAR_NINE) begin
      d = 64'(b - CHAR_ZERO);
      if (k == KIND_FLOAT && point_seen) begin
        if (frac_cnt >= FRAC_MAX) begin
          bad = 1'b1;
          return;
        end
        frac_cnt++;
      end
      if (acc > (SAT_LIMIT - d) / 10) begin
        acc = SAT_LIMIT;
        bad = 1'b1;
      end else begin
        acc = acc * 10 + d;
      end
    end else if (b == CHAR_DOT && k == KIND_FLOAT && !point_seen) begin
      point_seen = 1'b1;
    end else begin
      bad = 1'b1;
    end
  endfunction

  task automatic parse_nmea_byte(input logic [7:0] b, input logic first, input logic last,
                                 output bit made, output field_result_t r);
    bit ends;
    made = 1'b0;
    r = '0;
    ends = (b == CHAR_STAR) || (b == CHAR_CR) || (b == CHAR_LF) || (b == CHAR_DOLLAR);
    if (first) clear_search();
    if (done) return;
    case (ph)
      PH_SEARCH: begin
        if (b == CHAR_DOLLAR) begin
          ph = PH_HEADER;
          hdr_pos = '0;
          hdr_sum = '0;
        end
      end
      PH_HEADER: begin
        if (b == CHAR_DOLLAR) begin
          hdr_pos = '0;
          hdr_sum = '0;
        end else begin
          hdr_pos++;
          if (hdr_pos >= HDR_SUM_START) hdr_sum += 10'(b);
          if (hdr_pos >= HDR_LAST) begin
            if (sel < 3'(SENTENCE_COUNT) && hdr_sum == HEADER_SUMS[sel]) begin
              if (fnum == 5'd0 || fnum > FIELD_COUNTS[sel]) begin
                r = give(ST_NO_FIELD, KIND_FLOAT, '0, '0, '0);
                made = 1'b1;
                return;
              end
              ph = PH_COUNT;
              commas = '0;
            end else begin
              ph = PH_SEARCH;
            end
          end
        end
      end
      PH_COUNT: begin
        if (b == CHAR_COMMA) begin
          commas++;
          if (commas == fnum) begin
            ph = PH_FIELD;
            acc = '0;
            frac_cnt = '0;
            point_seen = 1'b0;
            first_char = '0;
            bad = 1'b0;
            started = 1'b0;
          end
        end else if (ends) begin
          r = give(ST_NO_FIELD, KIND_FLOAT, '0, '0, '0);
          made = 1'b1;
          return;
        end
      end
      PH_FIELD: begin
        if (b == CHAR_COMMA || ends) begin
          r = finish_field();
          made = 1'b1;
          return;
        end
        absorb(b);
      end
      default: ;
    endcase
    if (last) begin
      made = 1'b1;
      if (ph == PH_FIELD) begin
        r = finish_field();
      end else if (ph == PH_COUNT) begin
        r = give(ST_NO_FIELD, KIND_FLOAT, '0, '0, '0);
      end else begin
        r = give(ST_NO_SENTENCE, KIND_FLOAT, '0, '0, '0);
      end
    end
  endtask

  task automatic compare_field(input string what, input logic [31:0] want,
                               input logic [31:0] have);
    if (want !== have) begin
      fail_cnt++;
      if (fail_cnt <= 10) begin
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, have);
      end
    end
  endtask

  always @(posedge clk) begin
    field_result_t fresh;
    field_result_t oldest;
    bit            made;
    if (rst) begin
      sel = 3'd0;
      fnum = 5'd1;
      clear_search();
      field_results_due.delete();
    end else begin
      if (cfg_write) begin
        if (cfg_index == CFG_SENTENCE_SELECT) begin
          sel = cfg_data[2:0];
        end else if (cfg_index == CFG_FIELD_NUMBER) begin
          fnum = cfg_data[4:0];
        end
      end
      if (out_valid && out_ready) begin
        if (field_results_due.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= 10) begin
            $display("%0t: result with none predicted, status %0d mantissa %0d",
                     $time, status, mantissa);
          end
        end else begin
          oldest = field_results_due.pop_front();
          compare_field("status", 32'(oldest.st), 32'(status));
          compare_field("value_kind", 32'(oldest.kind), 32'(value_kind));
          compare_field("mantissa", oldest.mant, 32'(mantissa));
          compare_field("fraction_digits", 32'(oldest.frac), 32'(fraction_digits));
          compare_field("char_value", 32'(oldest.ch), 32'(char_value));
        end
      end
      if (in_valid && in_ready) begin
        parse_nmea_byte(data_byte, first_byte, last_byte, made, fresh);
        if (made) begin
          field_results_due.push_back(fresh);
          predicted++;
        end
      end
    end
    failures <= fail_cnt;
    awaiting <= field_results_due.size();
    results_due_total <= predicted;
  end

endmodule

`default_nettype wire

### tb/sv/tb_nmea_sentence_field_extractor.sv
`default_nettype none

module tb_nmea_sentence_field_extractor;
  timeunit 1ns;
  timeprecision 1ps;
  import nsfe_pkg::*;

  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 8;
  localparam int IDLE_PCT = 21;
  localparam int BYTE_TARGET = 750;
  localparam int RESULT_TARGET = 30;
  localparam int SENTENCE_FIELDS [SENTENCE_COUNT] = '{12, 9, 14, 17, 7, 7};

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index = CFG_SENTENCE_SELECT;
  logic [CFG_DATA_WIDTH-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic [7:0] data_byte = '0;
  logic first_byte = 1'b0;
  logic last_byte = 1'b0;
  logic out_ready = 1'b0;
  logic in_ready;
  logic out_valid;
  logic [1:0] status;
  logic [1:0] value_kind;
  logic [MANT_WIDTH-1:0] mantissa;
  logic [3:0] fraction_digits;
  logic [7:0] char_value;

  logic calm = 1'b0;
  logic hold_req = 1'b0;
  int failures;
  int awaiting;
  int results_due_total;
  int bytes_sent = 0;
  logic [2:0] cur_sel = 3'd0;
  logic [7:0] text_bytes [$];
  string sentence_names [SENTENCE_COUNT] = '{"RMC", "VTG", "GGA", "GSA", "GSV", "GLL"};
  string hex_digits = "0123456789ABCDEF";

  nmea_sentence_field_extractor uut (
    .clk, .rst, .cfg_write, .cfg_index, .cfg_data,
    .in_valid, .in_ready, .data_byte, .first_byte, .last_byte,
    .out_valid, .out_ready, .status, .value_kind, .mantissa, .fraction_digits, .char_value
  );

  nmea_field_checker watch (
    .clk, .rst, .cfg_write, .cfg_index, .cfg_data,
    .in_valid, .in_ready, .data_byte, .first_byte, .last_byte,
    .out_valid, .out_ready, .status, .value_kind, .mantissa, .fraction_digits, .char_value,
    .failures, .awaiting, .results_due_total
  );

  always #4 clk = ~clk;

  initial begin
    #2_000_000;
    $display("nmea_sentence_field_extractor verification failed");
    $finish;
  end

  // The long hold-off lets the result register and the input queue fill up.
  initial begin : receiver
    bit held = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !held) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  task automatic drive_byte(input logic [7:0] b, input logic f, input logic l);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= b;
    first_byte <= f;
    last_byte <= l;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_queued(input bit close);
    for (int i = 0; i < text_bytes.size(); i++) begin
      drive_byte(text_bytes[i], i == 0, close && (i == text_bytes.size() - 1));
    end
    text_bytes.delete();
  endtask

  task automatic queue_text(input string s);
    for (int i = 0; i < s.len(); i++) text_bytes.push_back(s[i]);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (awaiting != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_config(input logic [2:0] sel, input logic [4:0] fn);
    settle();
    cfg_write <= 1'b1;
    cfg_index <= CFG_SENTENCE_SELECT;
    cfg_data <= CFG_DATA_WIDTH'(sel);
    @(posedge clk);
    cfg_index <= CFG_FIELD_NUMBER;
    cfg_data <= fn;
    @(posedge clk);
    cfg_write <= 1'b0;
    cur_sel = sel;
  endtask

  task automatic run_directed(input logic [2:0] sel, input logic [4:0] fn, input string s);
    write_config(sel, fn);
    queue_text(s);
    send_queued(1'b1);
  endtask

  function automatic int digit_count();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(6, 12) : $urandom_range(0, 5);
  endfunction

  task automatic queue_digits(input int n, input bit nines);
    repeat (n) begin
      text_bytes.push_back(nines ? CHAR_NINE : CHAR_ZERO + 8'($urandom_range(0, 9)));
    end
  endtask

  task automatic queue_field(input kind_t k);
    int style;
    bit nines;
    style = $urandom_range(0, 99);
    nines = ($urandom_range(0, 7) == 0);
    if (style < 8) return;
    if (style < 14) begin
      repeat ($urandom_range(1, 3)) text_bytes.push_back(8'($urandom_range(0, 255)));
      return;
    end
    case (k)
      KIND_CHAR: begin
        if ($urandom_range(0, 3) == 0) begin
          text_bytes.push_back(8'($urandom_range(0, 255)));
        end else begin
          text_bytes.push_back(8'h41 + 8'($urandom_range(0, 25)));
        end
      end
      KIND_INT: begin
        queue_digits(1 + digit_count(), nines);
      end
      default: begin
        queue_digits(digit_count(), nines);
        if ($urandom_range(0, 3) != 0) begin
          text_bytes.push_back(CHAR_DOT);
          queue_digits(($urandom_range(0, 7) == 0) ? $urandom_range(9, 11)
                                                   : $urandom_range(0, 4), nines);
        end
      end
    endcase
    if (style >= 94) begin
      text_bytes.push_back(8'($urandom_range(8'h21, 8'h7E)));
      queue_digits($urandom_range(0, 2), 1'b0);
    end
  endtask

  task automatic queue_sentence(input int s_idx);
    int    nfields;
    string name;
    name = sentence_names[s_idx];
    text_bytes.push_back(CHAR_DOLLAR);
    if ($urandom_range(0, 9) == 0) begin
      queue_text("GP");
      text_bytes.push_back(CHAR_DOLLAR);
    end
    if ($urandom_range(0, 9) == 0) begin
      repeat (2) text_bytes.push_back(8'($urandom_range(0, 255)));
    end else begin
      queue_text("GP");
    end
    case ($urandom_range(0, 9))
      0: begin
        text_bytes.push_back(name[2]);
        text_bytes.push_back(name[0]);
        text_bytes.push_back(name[1]);
      end
      1: begin
        repeat (3) text_bytes.push_back(8'h41 + 8'($urandom_range(0, 25)));
      end
      default: begin
        queue_text(name);
      end
    endcase
    nfields = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 20) : SENTENCE_FIELDS[s_idx];
    for (int j = 0; j < nfields; j++) begin
      text_bytes.push_back(CHAR_COMMA);
      queue_field(TYPE_TAB[s_idx][j % FIELD_SLOTS]);
    end
    case ($urandom_range(0, 9))
      6: text_bytes.push_back(CHAR_STAR);
      7: text_bytes.push_back(CHAR_CR);
      8: text_bytes.push_back(CHAR_LF);
      9: ;
      default: begin
        text_bytes.push_back(CHAR_STAR);
        text_bytes.push_back(hex_digits[$urandom_range(0, 15)]);
        text_bytes.push_back(hex_digits[$urandom_range(0, 15)]);
        text_bytes.push_back(CHAR_CR);
        text_bytes.push_back(CHAR_LF);
      end
    endcase
  endtask

  task automatic send_random_buffer();
    if ($urandom_range(0, 29) == 0) begin
      text_bytes.push_back(8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(0, 3)) text_bytes.push_back(8'($urandom_range(0, 255)));
      repeat (($urandom_range(0, 3) == 0) ? 2 : 1) begin
        if (cur_sel < 3'(SENTENCE_COUNT) && $urandom_range(0, 9) < 7) begin
          queue_sentence(int'(cur_sel));
        end else begin
          queue_sentence($urandom_range(0, SENTENCE_COUNT - 1));
        end
      end
      repeat ($urandom_range(0, 2)) text_bytes.push_back(8'($urandom_range(0, 255)));
    end
    send_queued($urandom_range(0, 19) != 0);
  endtask

  initial begin : stimulus
    int         group;
    logic [2:0] sel;
    logic [4:0] fn;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    run_directed(3'd0, 5'd1, "$GPRMC,123519.00,A*6A\r\n");
    run_directed(3'd0, 5'd2, "$GPRMC,123519,A,4807.038,N*1F");
    run_directed(3'd1, 5'd1, "$GPVTG,054,T,034.4,M*11");
    run_directed(3'd2, 5'd6, "$GPGGA,1,2,N,3,E,4294967295,x");
    run_directed(3'd2, 5'd7, "$GPGGA,1,2,N,3,E,1,4294967296,x");
    run_directed(3'd0, 5'd3, "$GPRMC,1,A,12.1234567890,N");
    run_directed(3'd3, 5'd2, "$GPGSA,A,12a4,5");
    run_directed(3'd4, 5'd2, "$GPGSV,1,2.5,3");
    run_directed(3'd5, 5'd2, "$GPGLL,4916.45,,12311.12,W");
    run_directed(3'd5, 5'd5, "$GPGLL,1,N*11");
    run_directed(3'd0, 5'd3, "$GPRMC,1$GPRMC,2,3");
    run_directed(3'd4, 5'd1, "$GP$GPGSV,7,1*");
    run_directed(3'd7, 5'd1, "$GPRMC,1*");
    run_directed(3'd6, 5'd3, "$GPGSA,A,3,4");
    run_directed(3'd0, 5'd0, "$GPRMC,1");
    run_directed(3'd1, 5'd31, "$GPVTG,1,T");
    run_directed(3'd3, 5'd17, "$GPGSA,A,3,04,05,,09,12,,,24,,,,,2,1,31");
    run_directed(3'd2, 5'd1, "$GPGGA,092750.000\r");
    run_directed(3'd0, 5'd1, "$GPMCR,1.2.3,");
    run_directed(3'd0, 5'd3, "$GPRMC,1,A,.5\n");
    run_directed(3'd0, 5'd1, "$GPRMC,5.$");
    run_directed(3'd0, 5'd2, "$GPRMC,1,V,x,y");
    queue_text("$GPRMC,1,");
    text_bytes.push_back(8'hFF);
    queue_text("Z,");
    send_queued(1'b1);
    text_bytes = '{8'h00, 8'h80, 8'h7F, 8'hFF};
    send_queued(1'b1);
    queue_text("$");
    send_queued(1'b1);
    write_config(3'd0, 5'd1);
    queue_text("$GPRMC,5");
    send_queued(1'b0);
    queue_text("$GPRMC,6*");
    send_queued(1'b1);

    group = 0;
    while (group < 2 || bytes_sent < BYTE_TARGET || results_due_total < RESULT_TARGET) begin
      if ($urandom_range(0, 9) == 0) begin
        sel = 3'($urandom_range(6, 7));
      end else begin
        sel = 3'($urandom_range(0, SENTENCE_COUNT - 1));
      end
      if ($urandom_range(0, 9) == 0) begin
        fn = 5'($urandom_range(0, 31));
      end else begin
        fn = 5'($urandom_range(1, SENTENCE_FIELDS[(sel < 3'(SENTENCE_COUNT)) ? sel : 0]));
      end
      write_config(sel, fn);
      calm <= (group == 1);
      if (group == 0) begin
        hold_req <= 1'b1;
      end
      repeat ((group == 0) ? 2 : $urandom_range(1, 3)) send_random_buffer();
      group++;
    end
    calm <= 1'b0;
    settle();

    if (failures == 0 && awaiting == 0) begin
      $display("nmea_sentence_field_extractor verification clean");
    end else begin
      $display("nmea_sentence_field_extractor verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
